FILE: rtl/text_scrollback_line_writer_macros.svh
// Assertion macros for the scrollback line writer.
// Depends on nothing; included by the top level, which holds the assertions.
`ifndef TEXT_SCROLLBACK_LINE_WRITER_MACROS_SVH
`define TEXT_SCROLLBACK_LINE_WRITER_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define TSLW_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tslw: implication check failed");

// Next-cycle implication.
`define TSLW_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tslw: next-cycle check failed");

`else

`define TSLW_ASSERT_IMP(name, clk, rst, ante, cons)
`define TSLW_ASSERT_NXT(name, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/tslw_pkg.sv
// Shared types, codes and constants of the scrollback line writer.
// Depends on nothing; used by every module of the block.
package tslw_pkg;

   // Default sizes of the ring and of one line.
   localparam int unsigned DEPTH_DEFAULT    = 256;
   localparam int unsigned MAX_COLS_DEFAULT = 128;

   // Widest fields that the largest legal sizes need.
   localparam int unsigned SLOT_MAX_W = 12;
   localparam int unsigned CELL_MAX_W = 8;
   localparam int unsigned LEN_MAX_W  = 9;

   // Wrap width register.
   localparam logic [7:0]  COLS_RESET = 8'd80;
   localparam int unsigned COLS_MIN   = 32;

   // Byte codes with a meaning of their own.
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_BS    = 8'h08;
   localparam logic [7:0] PRINT_LO = 8'h20;
   localparam logic [7:0] PRINT_HI = 8'h7E;

   // Queue sizes between the parts.
   localparam int unsigned OPQ_DEPTH  = 4;
   localparam int unsigned RSP_DEPTH  = 4;
   localparam int unsigned RSP_CNT_W  = $clog2(RSP_DEPTH + 1);

   // Request codes on the input channel.
   typedef enum logic [1:0] {
      REQ_WRITE = 2'd0,
      REQ_CLEAR = 2'd1,
      REQ_READ  = 2'd2,
      REQ_NONE  = 2'd3
   } req_kind_type;

   // Work handed from the front part to the memory part.
   typedef enum logic [1:0] {
      OP_NOP  = 2'd0,
      OP_LEN  = 2'd1,
      OP_CHAR = 2'd2,
      OP_READ = 2'd3
   } op_kind_type;

   // Status reported with every item.
   typedef struct packed {
      logic [7:0] cursor_column;
      logic [7:0] cursor_line;
      logic [8:0] lines_kept;
      logic [7:0] oldest_slot;
   } stat_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [SLOT_MAX_W-1:0] slot;
      logic [CELL_MAX_W-1:0] pos;
      logic [6:0]            ch;
      logic [LEN_MAX_W-1:0]  len;
      logic [6:0]            col;
      stat_type              stat;
   } op_type;

   typedef struct packed {
      logic [6:0] read_char;
      logic [7:0] read_length;
      stat_type   stat;
   } rsp_type;

   // Occupancy of the back part, watched at the top level.
   typedef struct packed {
      logic                 s1_valid;
      logic [RSP_CNT_W-1:0] rsp_count;
   } back_stat_type;

endpackage

FILE: rtl/tslw_front.sv
// Front part: holds the ring pointers, the cursor and the wrap width register,
// classifies each item and builds the memory operation. Depends on tslw_pkg.
module tslw_front #(
   parameter int unsigned DEPTH    = tslw_pkg::DEPTH_DEFAULT,
   parameter int unsigned MAX_COLS = tslw_pkg::MAX_COLS_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [7:0]       csr_wr_data,
   input  logic             accept,
   input  logic [1:0]       req_type,
   input  logic [7:0]       char_in,
   input  logic [7:0]       read_line,
   input  logic [6:0]       read_col,
   output tslw_pkg::op_type op
);
   import tslw_pkg::*;

   localparam int unsigned SLOT_W = $clog2(DEPTH);
   localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
   localparam int unsigned LEN_W  = $clog2(MAX_COLS + 1);
   localparam int unsigned SUM_W  = SLOT_W + 1;
   localparam int unsigned RL_W   = (CNT_W > 8) ? CNT_W : 8;

   logic [SLOT_W-1:0] start_ff, start_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [SLOT_W-1:0] line_ff, line_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [LEN_W-1:0]  cursor_ff, cursor_in;
   logic [7:0]        cols_ff, cols_in;

   logic              ring_full;
   logic [SLOT_W-1:0] nl_slot, nl_start, nl_line;
   logic [CNT_W-1:0]  nl_count;
   logic [8:0]        wrap9;
   logic              wrap_hit;
   logic              read_hit;
   logic [SUM_W-1:0]  read_sum, read_slot;

   // Values that opening a new line would give.
   assign ring_full = (count_ff == CNT_W'(DEPTH));
   assign nl_slot   = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign nl_count  = ring_full ? count_ff : count_ff + 1'b1;
   assign nl_start  = !ring_full ? start_ff :
                      (start_ff == SLOT_W'(DEPTH - 1)) ? '0 : start_ff + 1'b1;
   assign nl_line   = ring_full ? line_ff : SLOT_W'(count_ff);

   // Wrap width, saturated to the legal range.
   always_comb begin
      if ({1'b0, cols_ff} < 9'(COLS_MIN)) begin
         wrap9 = 9'(COLS_MIN);
      end else if ({1'b0, cols_ff} > 9'(MAX_COLS)) begin
         wrap9 = 9'(MAX_COLS);
      end else begin
         wrap9 = {1'b0, cols_ff};
      end
   end
   assign wrap_hit = (9'(cursor_ff) >= wrap9);

   // Ring slot of the logical line that a read asks for.
   assign read_hit  = (RL_W'(read_line) < RL_W'(count_ff));
   assign read_sum  = SUM_W'(start_ff) + SUM_W'(read_line);
   assign read_slot = (read_sum >= SUM_W'(DEPTH)) ? read_sum - SUM_W'(DEPTH) : read_sum;

   // Item decode and next state.
   always_comb begin
      start_in  = start_ff;
      count_in  = count_ff;
      line_in   = line_ff;
      slot_in   = slot_ff;
      cursor_in = cursor_ff;
      op        = '0;
      op.kind   = OP_NOP;
      op.col    = read_col;
      unique case (req_kind_type'(req_type))
         REQ_WRITE: begin
            if (char_in == CH_LF) begin
               start_in  = nl_start;
               count_in  = nl_count;
               line_in   = nl_line;
               slot_in   = nl_slot;
               cursor_in = '0;
               op.kind   = OP_LEN;
               op.slot   = SLOT_MAX_W'(nl_slot);
               op.len    = '0;
            end else if (char_in == CH_BS) begin
               if (cursor_ff != '0) begin
                  cursor_in = cursor_ff - 1'b1;
                  op.kind   = OP_LEN;
                  op.slot   = SLOT_MAX_W'(slot_ff);
                  op.len    = LEN_MAX_W'(cursor_ff - 1'b1);
               end
            end else if (char_in >= PRINT_LO && char_in <= PRINT_HI) begin
               op.kind = OP_CHAR;
               op.ch   = char_in[6:0];
               if (wrap_hit) begin
                  start_in  = nl_start;
                  count_in  = nl_count;
                  line_in   = nl_line;
                  slot_in   = nl_slot;
                  cursor_in = LEN_W'(1);
                  op.slot   = SLOT_MAX_W'(nl_slot);
                  op.pos    = '0;
                  op.len    = LEN_MAX_W'(1);
               end else begin
                  cursor_in = cursor_ff + 1'b1;
                  op.slot   = SLOT_MAX_W'(slot_ff);
                  op.pos    = CELL_MAX_W'(cursor_ff);
                  op.len    = LEN_MAX_W'(cursor_ff + 1'b1);
               end
            end
         end
         REQ_CLEAR: begin
            start_in  = '0;
            count_in  = CNT_W'(1);
            line_in   = '0;
            slot_in   = '0;
            cursor_in = '0;
            op.kind   = OP_LEN;
            op.slot   = '0;
            op.len    = '0;
         end
         REQ_READ: begin
            if (read_hit) begin
               op.kind = OP_READ;
               op.slot = SLOT_MAX_W'(read_slot);
               op.pos  = CELL_MAX_W'(read_col);
            end
         end
         REQ_NONE: begin
            op.kind = OP_NOP;
         end
         default: begin
            op.kind = OP_NOP;
         end
      endcase
      op.stat.cursor_column = 8'(cursor_in);
      op.stat.cursor_line   = 8'(line_in);
      op.stat.lines_kept    = 9'(count_in);
      op.stat.oldest_slot   = 8'(start_in);
   end

   // Wrap width register.
   assign cols_in = csr_wr_en ? csr_wr_data : cols_ff;

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= '0;
         count_ff  <= CNT_W'(1);
         line_ff   <= '0;
         slot_ff   <= '0;
         cursor_ff <= '0;
         cols_ff   <= COLS_RESET;
      end else begin
         cols_ff <= cols_in;
         if (accept) begin
            start_ff  <= start_in;
            count_ff  <= count_in;
            line_ff   <= line_in;
            slot_ff   <= slot_in;
            cursor_ff <= cursor_in;
         end
      end
   end

endmodule

FILE: rtl/tslw_op_queue.sv
// Short queue of memory operations between the front and back parts.
// Depends on tslw_pkg.
module tslw_op_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tslw_pkg::op_type push_op,
   output logic             full,
   input  logic             pop,
   output tslw_pkg::op_type head_op,
   output logic             empty
);
   import tslw_pkg::*;

   localparam int unsigned PTR_W = $clog2(OPQ_DEPTH);
   localparam int unsigned CNT_W = $clog2(OPQ_DEPTH + 1);

   op_type             entry_ff [OPQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(OPQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head_op = entry_ff[rd_ptr_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(OPQ_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(OPQ_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_op;
      end
   end

endmodule

FILE: rtl/tslw_back.sv
// Back part: the cell and line length memories, the read stage and the
// result queue that drives the result channel. Depends on tslw_pkg.
module tslw_back #(
   parameter int unsigned DEPTH    = tslw_pkg::DEPTH_DEFAULT,
   parameter int unsigned MAX_COLS = tslw_pkg::MAX_COLS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  tslw_pkg::op_type        head_op,
   input  logic                    q_empty,
   output logic                    q_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output tslw_pkg::rsp_type       rsp,
   output tslw_pkg::back_stat_type stat
);
   import tslw_pkg::*;

   localparam int unsigned SLOT_W    = $clog2(DEPTH);
   localparam int unsigned ROW_W     = $clog2(MAX_COLS);
   localparam int unsigned LEN_W     = $clog2(MAX_COLS + 1);
   localparam int unsigned TXT_DEPTH = DEPTH * (1 << ROW_W);
   localparam int unsigned RPTR_W    = $clog2(RSP_DEPTH);

   // Memories.
   logic [6:0]       txt_mem [TXT_DEPTH];
   logic [LEN_W-1:0] len_mem [DEPTH];

   logic [SLOT_W+ROW_W-1:0] txt_addr;
   logic [SLOT_W-1:0]       len_addr;
   logic                    issue, txt_we, len_we;
   logic                    slot0_ff, slot0_in;

   // Read stage.
   logic             s1_valid_ff;
   logic             s1_read_ff;
   logic             s1_zero_ff;
   logic [6:0]       s1_col_ff;
   stat_type         s1_stat_ff;
   logic [6:0]       txt_rd_ff;
   logic [LEN_W-1:0] len_rd_ff;
   rsp_type          s1_rsp;
   logic [LEN_W-1:0] s1_len;

   // Result queue.
   rsp_type              rq_ff [RSP_DEPTH];
   logic [RPTR_W-1:0]    rq_wr_ff, rq_wr_in;
   logic [RPTR_W-1:0]    rq_rd_ff, rq_rd_in;
   logic [RSP_CNT_W-1:0] rq_cnt_ff, rq_cnt_in;
   logic                 rq_pop;

   // Issue only when the result queue has room for everything in flight.
   assign issue = !q_empty &&
                  ((RSP_CNT_W + 1)'(rq_cnt_ff) + (RSP_CNT_W + 1)'(s1_valid_ff)
                   < (RSP_CNT_W + 1)'(RSP_DEPTH));
   assign q_pop = issue;

   assign txt_addr = {SLOT_W'(head_op.slot), ROW_W'(head_op.pos)};
   assign len_addr = SLOT_W'(head_op.slot);
   assign txt_we   = issue && (head_op.kind == OP_CHAR);
   assign len_we   = issue && (head_op.kind == OP_CHAR || head_op.kind == OP_LEN);

   // Slot 0 holds no written length after reset until its first write.
   assign slot0_in = slot0_ff || (len_we && len_addr == '0);

   always_ff @(posedge clock) begin
      if (txt_we) begin
         txt_mem[txt_addr] <= head_op.ch;
      end
      txt_rd_ff <= txt_mem[txt_addr];
   end

   always_ff @(posedge clock) begin
      if (len_we) begin
         len_mem[len_addr] <= LEN_W'(head_op.len);
      end
      len_rd_ff <= len_mem[len_addr];
   end

   // Read stage control and side data.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         slot0_ff    <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         slot0_ff    <= slot0_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_read_ff <= (head_op.kind == OP_READ);
      s1_zero_ff <= (len_addr == '0) && !slot0_ff;
      s1_col_ff  <= head_op.col;
      s1_stat_ff <= head_op.stat;
   end

   // Form the result from the memory data.
   always_comb begin
      s1_len = (s1_read_ff && !s1_zero_ff) ? len_rd_ff : '0;
      s1_rsp.read_length = 8'(s1_len);
      s1_rsp.read_char   = (9'(s1_col_ff) < 9'(s1_len)) ? txt_rd_ff : 7'd0;
      s1_rsp.stat        = s1_stat_ff;
   end

   // Result queue pointers and count.
   assign rq_pop    = rsp_pop && !rsp_empty;
   assign rsp_empty = (rq_cnt_ff == '0);
   assign rsp       = rq_ff[rq_rd_ff];

   always_comb begin
      rq_wr_in  = rq_wr_ff;
      rq_rd_in  = rq_rd_ff;
      rq_cnt_in = rq_cnt_ff;
      if (s1_valid_ff) begin
         rq_wr_in = (rq_wr_ff == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rq_wr_ff + 1'b1;
      end
      if (rq_pop) begin
         rq_rd_in = (rq_rd_ff == RPTR_W'(RSP_DEPTH - 1)) ? '0 : rq_rd_ff + 1'b1;
      end
      if (s1_valid_ff && !rq_pop) begin
         rq_cnt_in = rq_cnt_ff + 1'b1;
      end else if (rq_pop && !s1_valid_ff) begin
         rq_cnt_in = rq_cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rq_wr_ff  <= '0;
         rq_rd_ff  <= '0;
         rq_cnt_ff <= '0;
      end else begin
         rq_wr_ff  <= rq_wr_in;
         rq_rd_ff  <= rq_rd_in;
         rq_cnt_ff <= rq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         rq_ff[rq_wr_ff] <= s1_rsp;
      end
   end

   assign stat.s1_valid  = s1_valid_ff;
   assign stat.rsp_count = rq_cnt_ff;

endmodule

FILE: rtl/text_scrollback_line_writer.sv
// Scrollback line writer, top level: front part, operation queue, back part.
// Depends on tslw_pkg, tslw_front, tslw_op_queue, tslw_back and the macros header.
//
// Use: items enter through a queue-like port (req_push, req_full). Each item
// is a byte write, a clear, a cell read or a no-op, chosen by req_type. Every
// item gives exactly one result on the queue-like result port (rsp_empty,
// rsp_pop), in order, carrying the read cell and length and the cursor and
// ring status after the item.
// Throughput: one item per cycle while results are popped. The front part
// updates the ring pointers and cursor in the accepting cycle; the back part
// does one memory access per item on a single port of each of the cell and
// length memories. Items pass the operation queue, read stage and result queue.
// When the receiver stops popping, the four-entry result queue fills, the back
// part stops issuing, the four-entry operation queue fills and req_full rises.
// Reset clears the ring to one empty line, the cursor and both queues and sets the
// wrap width to 80; no clearing pass follows reset. The user writes the wrap width
// through csr_wr_en and csr_wr_data only while the block is idle; not enforced.
`include "text_scrollback_line_writer_macros.svh"

module text_scrollback_line_writer #(
   parameter int unsigned DEPTH    = tslw_pkg::DEPTH_DEFAULT,
   parameter int unsigned MAX_COLS = tslw_pkg::MAX_COLS_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_push,
   output logic       req_full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_read_line,
   input  logic [6:0] req_read_col,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [6:0] rsp_read_char,
   output logic [7:0] rsp_read_length,
   output logic [7:0] rsp_cursor_column,
   output logic [7:0] rsp_cursor_line,
   output logic [8:0] rsp_lines_kept,
   output logic [7:0] rsp_oldest_slot
);
   import tslw_pkg::*;

   logic          accept;
   op_type        front_op;
   op_type        head_op;
   logic          q_empty, q_pop;
   rsp_type       rsp;
   back_stat_type back_stat;

   assign accept = req_push && !req_full;

   // Classification and pointer update.
   tslw_front #(
      .DEPTH    (DEPTH),
      .MAX_COLS (MAX_COLS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .accept      (accept),
      .req_type    (req_type),
      .char_in     (req_char_in),
      .read_line   (req_read_line),
      .read_col    (req_read_col),
      .op          (front_op)
   );

   // Decoupling queue.
   tslw_op_queue u_op_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .push_op (front_op),
      .full    (req_full),
      .pop     (q_pop),
      .head_op (head_op),
      .empty   (q_empty)
   );

   // Memory access and result delivery.
   tslw_back #(
      .DEPTH    (DEPTH),
      .MAX_COLS (MAX_COLS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .head_op   (head_op),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp       (rsp),
      .stat      (back_stat)
   );

   assign rsp_read_char     = rsp.read_char;
   assign rsp_read_length   = rsp.read_length;
   assign rsp_cursor_column = rsp.stat.cursor_column;
   assign rsp_cursor_line   = rsp.stat.cursor_line;
   assign rsp_lines_kept    = rsp.stat.lines_kept;
   assign rsp_oldest_slot   = rsp.stat.oldest_slot;

   // An accepted item is waiting in the operation queue on the next cycle.
   `TSLW_ASSERT_NXT(a_accept_queued, clock, reset, accept, !q_empty)
   // A finished read stage always lands in the result queue.
   `TSLW_ASSERT_NXT(a_stage_delivered, clock, reset, back_stat.s1_valid, !rsp_empty)
   // The issue credit never lets the result queue overflow.
   `TSLW_ASSERT_IMP(a_no_overflow, clock, reset,
      back_stat.rsp_count == RSP_CNT_W'(RSP_DEPTH), !back_stat.s1_valid)

endmodule

FILE: tb/tslw_scrollback_checker.sv
// Checker for the scrollback line writer: it watches the item and result channels,
// predicts every result and compares it field by field. Depends on tslw_pkg.
module tslw_scrollback_checker (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [7:0] csr_wr_data,
   input  logic       req_push,
   input  logic       req_full,
   input  logic [1:0] req_type,
   input  logic [7:0] req_char_in,
   input  logic [7:0] req_read_line,
   input  logic [6:0] req_read_col,
   input  logic       rsp_empty,
   input  logic       rsp_pop,
   input  logic [6:0] rsp_read_char,
   input  logic [7:0] rsp_read_length,
   input  logic [7:0] rsp_cursor_column,
   input  logic [7:0] rsp_cursor_line,
   input  logic [8:0] rsp_lines_kept,
   input  logic [7:0] rsp_oldest_slot,
   output int         fail_count,
   output int         results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   import tslw_pkg::*;

   localparam int unsigned RING_LINES = DEPTH_DEFAULT;
   localparam int unsigned LINE_COLS  = MAX_COLS_DEFAULT;

   // Shadow copy of the ring, the cursor and the wrap width register.
   logic [6:0] cell_text [RING_LINES][LINE_COLS];
   logic [7:0] line_len [RING_LINES];
   logic [7:0] first_slot;
   logic [8:0] kept;
   logic [7:0] cur_line;
   logic [7:0] cur_col;
   logic [7:0] width_reg;

   rsp_type expected_results [$];
   int      mismatches = 0;
   int      owed_q = 0;

   assign fail_count   = mismatches;
   assign results_owed = owed_q;

   function automatic logic [7:0] slot_for(input logic [7:0] logical);
      return first_slot + logical;
   endfunction

   // The register is used saturated to the legal line widths.
   function automatic logic [7:0] wrap_cols();
      if (width_reg < COLS_MIN) return 8'(COLS_MIN);
      if (width_reg > LINE_COLS) return 8'(LINE_COLS);
      return width_reg;
   endfunction

   task automatic reset_ring();
      for (int i = 0; i < RING_LINES; i++) line_len[i] = '0;
      first_slot = '0;
      kept       = 9'd1;
      cur_line   = '0;
      cur_col    = '0;
   endtask

   // Open a new line; a full ring drops its oldest line.
   task automatic open_line();
      logic [7:0] next;
      if (kept < RING_LINES) begin
         next = kept[7:0];
         kept = kept + 9'd1;
      end else begin
         first_slot = first_slot + 8'd1;
         next       = 8'(RING_LINES - 1);
      end
      cur_line = next;
      cur_col  = '0;
      line_len[slot_for(next)] = '0;
   endtask

   task automatic feed_byte(input logic [7:0] ch);
      logic [7:0] slot;
      if (ch == CH_CR) begin
         // Carriage return is ignored.
      end else if (ch == CH_LF) begin
         open_line();
      end else if (ch == CH_BS) begin
         if (cur_col > 0) begin
            cur_col = cur_col - 8'd1;
            line_len[slot_for(cur_line)] = cur_col;
         end
      end else if (ch >= PRINT_LO && ch <= PRINT_HI) begin
         if (cur_col >= wrap_cols()) open_line();
         slot = slot_for(cur_line);
         cell_text[slot][cur_col[6:0]] = ch[6:0];
         cur_col = cur_col + 8'd1;
         line_len[slot] = cur_col;
      end
   endtask

   // Work out the result of one accepted item and update the shadow state.
   task automatic predict_item(input logic [1:0] kind, input logic [7:0] ch,
                               input logic [7:0] line, input logic [6:0] col,
                               output rsp_type res);
      logic [7:0] slot;
      res = '0;
      case (req_kind_type'(kind))
         REQ_WRITE: feed_byte(ch);
         REQ_CLEAR: reset_ring();
         REQ_READ: begin
            if ({1'b0, line} < kept) begin
               slot = slot_for(line);
               res.read_length = line_len[slot];
               if ({1'b0, col} < line_len[slot]) res.read_char = cell_text[slot][col];
            end
         end
         default: ;
      endcase
      res.stat.cursor_column = cur_col;
      res.stat.cursor_line   = cur_line;
      res.stat.lines_kept    = kept;
      res.stat.oldest_slot   = first_slot;
   endtask

   function automatic int field_differs(input string name, input logic [8:0] want,
                                        input logic [8:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         return 1;
      end
      return 0;
   endfunction

   // Both channels are sampled at the rising edge, before the drivers update.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      int      wrong;
      if (reset) begin
         reset_ring();
         width_reg = COLS_RESET;
         expected_results.delete();
      end else begin
         if (csr_wr_en) width_reg = csr_wr_data;
         if (req_push && !req_full) begin
            predict_item(req_type, req_char_in, req_read_line, req_read_col, want);
            expected_results.push_back(want);
         end
         if (rsp_pop && !rsp_empty) begin
            if (expected_results.size() == 0) begin
               $error("result item arrived with no item outstanding");
               mismatches++;
            end else begin
               want = expected_results.pop_front();
               got.read_char          = rsp_read_char;
               got.read_length        = rsp_read_length;
               got.stat.cursor_column = rsp_cursor_column;
               got.stat.cursor_line   = rsp_cursor_line;
               got.stat.lines_kept    = rsp_lines_kept;
               got.stat.oldest_slot   = rsp_oldest_slot;
               wrong = field_differs("read_char", want.read_char, got.read_char)
                     + field_differs("read_length", want.read_length, got.read_length)
                     + field_differs("cursor_column", want.stat.cursor_column,
                                     got.stat.cursor_column)
                     + field_differs("cursor_line", want.stat.cursor_line,
                                     got.stat.cursor_line)
                     + field_differs("lines_kept", want.stat.lines_kept,
                                     got.stat.lines_kept)
                     + field_differs("oldest_slot", want.stat.oldest_slot,
                                     got.stat.oldest_slot);
               if (wrong != 0) mismatches++;
            end
         end
      end
      owed_q <= expected_results.size();
   end

endmodule

FILE: tb/tb_text_scrollback_line_writer.sv
// Top of the scrollback line writer testbench: clock, reset, item stimulus and verdict.
// Depends on tslw_pkg, text_scrollback_line_writer and tslw_scrollback_checker.
module tb_text_scrollback_line_writer;
   timeunit 1ns;
   timeprecision 1ps;

   import tslw_pkg::*;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [7:0] csr_wr_data = '0;
   logic       req_push = 1'b0;
   logic       req_full;
   logic [1:0] req_type = REQ_WRITE;
   logic [7:0] req_char_in = '0;
   logic [7:0] req_read_line = '0;
   logic [6:0] req_read_col = '0;
   logic       rsp_empty;
   logic       rsp_pop = 1'b0;
   logic [6:0] rsp_read_char;
   logic [7:0] rsp_read_length;
   logic [7:0] rsp_cursor_column;
   logic [7:0] rsp_cursor_line;
   logic [8:0] rsp_lines_kept;
   logic [7:0] rsp_oldest_slot;

   int         fail_count;
   int         results_owed;
   logic       idle_on = 1'b1;
   int         stall_left = 0;
   int         approx_lines = 0;

   text_scrollback_line_writer u_top (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_type          (req_type),
      .req_char_in       (req_char_in),
      .req_read_line     (req_read_line),
      .req_read_col      (req_read_col),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_length   (rsp_read_length),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_line   (rsp_cursor_line),
      .rsp_lines_kept    (rsp_lines_kept),
      .rsp_oldest_slot   (rsp_oldest_slot)
   );

   tslw_scrollback_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_type          (req_type),
      .req_char_in       (req_char_in),
      .req_read_line     (req_read_line),
      .req_read_col      (req_read_col),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_read_char     (rsp_read_char),
      .rsp_read_length   (rsp_read_length),
      .rsp_cursor_column (rsp_cursor_column),
      .rsp_cursor_line   (rsp_cursor_line),
      .rsp_lines_kept    (rsp_lines_kept),
      .rsp_oldest_slot   (rsp_oldest_slot),
      .fail_count        (fail_count),
      .results_owed      (results_owed)
   );

   // 8 ns clock.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Result side: pop every cycle, with short random stalls while idling is on.
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_pop    <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
         stall_left <= $urandom_range(0, 2);
         rsp_pop    <= 1'b0;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   // Offer one item and hold it until the edge that accepts it.
   task automatic push_item(input req_kind_type kind, input logic [7:0] ch,
                            input logic [7:0] line, input logic [6:0] col);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_push      <= 1'b1;
      req_type      <= kind;
      req_char_in   <= ch;
      req_read_line <= line;
      req_read_col  <= col;
      do @(posedge clock); while (req_full);
      if (kind == REQ_CLEAR) approx_lines = 0;
      else if (kind == REQ_WRITE && ch == CH_LF && approx_lines < 255) approx_lines++;
   endtask

   // Let every outstanding item come back before touching the register.
   task automatic drain_items();
      req_push <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_columns(input logic [7:0] cols);
      drain_items();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cols;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   // One stretch of random items; the weights shape how lines are built.
   task automatic run_phase(input int count, input int print_pct, input int lf_pct,
                            input int bs_pct, input bit with_clears);
      int         r;
      logic [7:0] line;
      logic [6:0] col;
      for (int n = 0; n < count; n++) begin
         r    = $urandom_range(0, 99);
         line = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(0, approx_lines))
                                           : 8'($urandom_range(0, 255));
         col  = ($urandom_range(0, 1) == 0) ? 7'($urandom_range(0, 40))
                                            : 7'($urandom_range(0, 127));
         if (r < print_pct)
            push_item(REQ_WRITE, 8'($urandom_range(PRINT_LO, PRINT_HI)), line, col);
         else if (r < print_pct + lf_pct)
            push_item(REQ_WRITE, CH_LF, line, col);
         else if (r < print_pct + lf_pct + bs_pct)
            push_item(REQ_WRITE, CH_BS, line, col);
         else if (r < print_pct + lf_pct + bs_pct + 4)
            push_item(REQ_WRITE, CH_CR, line, col);
         else if (r < print_pct + lf_pct + bs_pct + 8)
            push_item(REQ_WRITE, 8'($urandom_range(0, 255)), line, col);
         else if (r < 97)
            push_item(REQ_READ, 8'($urandom_range(0, 255)), line, col);
         else if (r < 98)
            push_item(REQ_NONE, 8'($urandom_range(0, 255)), line, col);
         else if (with_clears)
            push_item(REQ_CLEAR, 8'($urandom_range(0, 255)), line, col);
         else
            push_item(REQ_READ, 8'($urandom_range(0, 255)), line, col);
      end
   endtask

   // Generous limit on the whole run.
   initial begin
      #2ms;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed items at the reset wrap width.
      push_item(REQ_READ, 8'h00, 8'd0, 7'd0);
      push_item(REQ_WRITE, PRINT_LO, 8'd0, 7'd0);
      push_item(REQ_WRITE, PRINT_HI, 8'd0, 7'd0);
      push_item(REQ_WRITE, CH_CR, 8'd0, 7'd0);
      push_item(REQ_WRITE, 8'h1F, 8'd0, 7'd0);
      push_item(REQ_WRITE, 8'h7F, 8'd0, 7'd0);
      push_item(REQ_WRITE, 8'h80, 8'd0, 7'd0);
      push_item(REQ_WRITE, 8'hFF, 8'd0, 7'd0);
      push_item(REQ_READ, 8'h00, 8'd0, 7'd0);
      push_item(REQ_READ, 8'h00, 8'd0, 7'd1);
      push_item(REQ_READ, 8'h00, 8'd0, 7'd2);
      push_item(REQ_READ, 8'hFF, 8'd255, 7'd127);
      push_item(REQ_WRITE, CH_BS, 8'd0, 7'd0);
      push_item(REQ_WRITE, CH_BS, 8'd0, 7'd0);
      push_item(REQ_WRITE, CH_BS, 8'd0, 7'd0);
      push_item(REQ_WRITE, CH_LF, 8'd0, 7'd0);
      push_item(REQ_WRITE, 8'h41, 8'd0, 7'd0);
      push_item(REQ_NONE, 8'hFF, 8'd255, 7'd127);
      push_item(REQ_READ, 8'h00, 8'd1, 7'd0);
      push_item(REQ_READ, 8'h00, 8'd2, 7'd0);
      push_item(REQ_CLEAR, 8'h00, 8'd0, 7'd0);
      push_item(REQ_READ, 8'h00, 8'd1, 7'd0);
      push_item(REQ_READ, 8'h00, 8'd0, 7'd0);

      // Many newlines, so many new lines are opened in the ring.
      run_phase(400, 40, 25, 6, 1'b0);

      // Narrowest width: printable runs wrap often.
      write_columns(8'd32);
      run_phase(400, 60, 8, 6, 1'b0);

      // Widest width: long lines up to the last readable column.
      write_columns(8'd128);
      run_phase(350, 65, 3, 10, 1'b0);

      // Register values outside the legal widths are saturated.
      write_columns(8'd0);
      run_phase(150, 55, 10, 6, 1'b1);
      write_columns(8'd255);
      run_phase(150, 60, 5, 6, 1'b1);
      write_columns(8'($urandom_range(129, 254)));
      run_phase(150, 50, 15, 6, 1'b1);

      // Last part at a random legal width, with no idling on either side.
      write_columns(8'($urandom_range(33, 127)));
      idle_on <= 1'b0;
      run_phase(300, 45, 20, 6, 1'b1);

      drain_items();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/tslw_pkg.sv
rtl/tslw_front.sv
rtl/tslw_op_queue.sv
rtl/tslw_back.sv
rtl/text_scrollback_line_writer.sv
tb/tslw_scrollback_checker.sv
tb/tb_text_scrollback_line_writer.sv
